>>> design/tcdr_pkg.sv
// Shared types, constants, font table and code mapping for the text-cell display refresher.
`default_nettype none

package tcdr_pkg;

  // Fixed geometry of the display and the font.
  localparam int unsigned GLYPH_WIDTH  = 6;
  localparam int unsigned PAGE_WIDTH   = 128;
  localparam int unsigned GLYPH_COUNT  = 49;
  localparam int unsigned HEADER_BYTES = 2;

  // Field widths.
  localparam int unsigned COL_W   = 5;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned CODE_W  = 7;
  localparam int unsigned GLYPH_W = 6;
  localparam int unsigned SUB_W   = 3;

  // The scan of a page starts at pixel column PAGE_WIDTH-1.
  localparam int unsigned START_CELL = (PAGE_WIDTH - 1) / GLYPH_WIDTH;
  localparam int unsigned START_SUB  = (PAGE_WIDTH - 1) % GLYPH_WIDTH;

  // Command bytes that open every refresh.
  localparam logic [7:0] CMD_LOW_COL  = 8'h00;
  localparam logic [7:0] CMD_HIGH_COL = 8'h10;

  // Operation selector of an input item.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  // Result of mapping a character code to a glyph.
  typedef struct packed {
    logic               hit;
    logic [GLYPH_W-1:0] glyph;
  } map_t;

  // Position of the refresh scan, handed from the scan counter to the sequencer.
  typedef struct packed {
    logic             header;
    logic             cmd_high;
    logic             last;
    logic [ROW_W-1:0] page;
    logic [COL_W-1:0] col;
    logic [SUB_W-1:0] sub;
  } scan_t;

  // 6x8 font, one byte per pixel column, bit 0 at the top.
  localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_WIDTH] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd124, 8'd10,  8'd9,   8'd10,  8'd124, 8'd0},
    '{8'd127, 8'd73,  8'd73,  8'd78,  8'd48,  8'd0},
    '{8'd62,  8'd65,  8'd65,  8'd65,  8'd34,  8'd0},
    '{8'd127, 8'd65,  8'd65,  8'd34,  8'd28,  8'd0},
    '{8'd127, 8'd73,  8'd73,  8'd73,  8'd65,  8'd0},
    '{8'd127, 8'd9,   8'd9,   8'd9,   8'd1,   8'd0},
    '{8'd62,  8'd65,  8'd73,  8'd73,  8'd58,  8'd0},
    '{8'd127, 8'd8,   8'd8,   8'd8,   8'd127, 8'd0},
    '{8'd0,   8'd65,  8'd127, 8'd65,  8'd0,   8'd0},
    '{8'd0,   8'd32,  8'd65,  8'd63,  8'd1,   8'd0},
    '{8'd127, 8'd8,   8'd20,  8'd34,  8'd65,  8'd0},
    '{8'd127, 8'd64,  8'd64,  8'd64,  8'd64,  8'd0},
    '{8'd127, 8'd2,   8'd12,  8'd2,   8'd127, 8'd0},
    '{8'd127, 8'd6,   8'd8,   8'd48,  8'd127, 8'd0},
    '{8'd62,  8'd65,  8'd65,  8'd65,  8'd62,  8'd0},
    '{8'd127, 8'd9,   8'd9,   8'd9,   8'd6,   8'd0},
    '{8'd62,  8'd65,  8'd81,  8'd33,  8'd94,  8'd0},
    '{8'd127, 8'd9,   8'd25,  8'd41,  8'd70,  8'd0},
    '{8'd70,  8'd73,  8'd73,  8'd73,  8'd49,  8'd0},
    '{8'd1,   8'd1,   8'd127, 8'd1,   8'd1,   8'd0},
    '{8'd63,  8'd64,  8'd64,  8'd64,  8'd63,  8'd0},
    '{8'd31,  8'd32,  8'd64,  8'd32,  8'd31,  8'd0},
    '{8'd63,  8'd64,  8'd56,  8'd64,  8'd63,  8'd0},
    '{8'd99,  8'd20,  8'd8,   8'd20,  8'd99,  8'd0},
    '{8'd7,   8'd8,   8'd112, 8'd8,   8'd7,   8'd0},
    '{8'd97,  8'd81,  8'd73,  8'd69,  8'd67,  8'd0},
    '{8'd62,  8'd81,  8'd73,  8'd69,  8'd62,  8'd0},
    '{8'd0,   8'd66,  8'd127, 8'd64,  8'd0,   8'd0},
    '{8'd66,  8'd97,  8'd81,  8'd73,  8'd70,  8'd0},
    '{8'd33,  8'd65,  8'd69,  8'd75,  8'd49,  8'd0},
    '{8'd24,  8'd20,  8'd18,  8'd127, 8'd16,  8'd0},
    '{8'd71,  8'd69,  8'd69,  8'd69,  8'd57,  8'd0},
    '{8'd60,  8'd74,  8'd73,  8'd73,  8'd48,  8'd0},
    '{8'd1,   8'd113, 8'd9,   8'd5,   8'd3,   8'd0},
    '{8'd54,  8'd73,  8'd73,  8'd73,  8'd54,  8'd0},
    '{8'd6,   8'd73,  8'd73,  8'd41,  8'd30,  8'd0},
    '{8'd0,   8'd54,  8'd54,  8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd95,  8'd0,   8'd0,   8'd0},
    '{8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd0},
    '{8'd8,   8'd28,  8'd42,  8'd8,   8'd8,   8'd0},
    '{8'd8,   8'd8,   8'd42,  8'd28,  8'd8,   8'd0},
    '{8'd16,  8'd32,  8'd126, 8'd32,  8'd16,  8'd0},
    '{8'd8,   8'd4,   8'd126, 8'd4,   8'd8,   8'd0},
    '{8'd0,   8'd0,   8'd126, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd96,  8'd48,  8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd96,  8'd96,  8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd2,   8'd5,   8'd2,   8'd0},
    '{8'd35,  8'd19,  8'd8,   8'd4,   8'd50,  8'd49}
  };

  // Font lookup; glyph indices past the table read as blank.
  function automatic logic [7:0] font_byte(logic [GLYPH_W-1:0] glyph, logic [SUB_W-1:0] sub);
    logic [7:0] result;
    result = 8'd0;
    if (glyph < GLYPH_W'(GLYPH_COUNT) && sub < SUB_W'(GLYPH_WIDTH)) begin
      result = FONT_ROM[glyph][sub];
    end
    return result;
  endfunction

  // Maps an ASCII code to its glyph index; hit is low for codes without a glyph.
  function automatic map_t map_code(logic [CODE_W-1:0] code);
    map_t m;
    m.hit   = 1'b1;
    m.glyph = '0;
    if (code >= 7'd65 && code <= 7'd90) begin
      // Upper-case letters map to 1..26.
      m.glyph = GLYPH_W'(code - 7'd64);
    end else if (code >= 7'd48 && code <= 7'd57) begin
      // Digits map to 27..36.
      m.glyph = GLYPH_W'(code - 7'd21);
    end else begin
      case (code)
        7'd32:   m.glyph = 6'd0;   // space
        7'd58:   m.glyph = 6'd37;  // colon
        7'd33:   m.glyph = 6'd38;  // exclamation mark
        7'd45:   m.glyph = 6'd39;  // minus
        7'd60:   m.glyph = 6'd40;  // less-than
        7'd62:   m.glyph = 6'd41;  // greater-than
        7'd118:  m.glyph = 6'd42;  // small v, down arrow
        7'd94:   m.glyph = 6'd43;  // caret, up arrow
        7'd124:  m.glyph = 6'd44;  // vertical bar
        7'd44:   m.glyph = 6'd45;  // comma
        7'd46:   m.glyph = 6'd46;  // period
        7'd111:  m.glyph = 6'd47;  // small o, degree sign
        7'd37:   m.glyph = 6'd48;  // percent
        default: m.hit   = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/tcdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcdr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data is valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/tcdr_scan.sv
// Refresh scan counter: byte position, page, character cell and glyph column.
`default_nettype none

module tcdr_scan #(
  parameter int unsigned TEXT_ROWS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          advance_i,
  output tcdr_pkg::scan_t    scan_o
);

  import tcdr_pkg::*;

  localparam int unsigned LAST_POS = HEADER_BYTES + TEXT_ROWS * PAGE_WIDTH - 1;
  localparam int unsigned POS_W    = $clog2(LAST_POS + 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [ROW_W-1:0] page_q, page_d;
  logic [COL_W-1:0] cell_q, cell_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic             header;

  assign header = pos_q < POS_W'(HEADER_BYTES);

  // Pixel columns run from the right edge down to zero; a page wrap moves to the next page.
  always_comb begin
    pos_d  = pos_q;
    page_d = page_q;
    cell_d = cell_q;
    sub_d  = sub_q;
    if (start_i) begin
      pos_d  = '0;
      page_d = '0;
      cell_d = COL_W'(START_CELL);
      sub_d  = SUB_W'(START_SUB);
    end else if (advance_i) begin
      pos_d = pos_q + POS_W'(1);
      if (!header) begin
        if (sub_q == '0) begin
          if (cell_q == '0) begin
            page_d = page_q + ROW_W'(1);
            cell_d = COL_W'(START_CELL);
            sub_d  = SUB_W'(START_SUB);
          end else begin
            cell_d = cell_q - COL_W'(1);
            sub_d  = SUB_W'(GLYPH_WIDTH - 1);
          end
        end else begin
          sub_d = sub_q - SUB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      page_q <= '0;
      cell_q <= '0;
      sub_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      page_q <= page_d;
      cell_q <= cell_d;
      sub_q  <= sub_d;
    end
  end

  // The second header byte is the high column command.
  assign scan_o.header   = header;
  assign scan_o.cmd_high = pos_q[0];
  assign scan_o.last     = pos_q == POS_W'(LAST_POS);
  assign scan_o.page     = page_q;
  assign scan_o.col      = cell_q;
  assign scan_o.sub      = sub_q;

endmodule

`default_nettype wire

>>> design/text_cell_display_refresher_core.sv
// Top level of the text-cell display refresher: sequencer, cell store and output register.
//
// Usage:
//   Input items arrive on the s_axis channel. tuser selects the operation: write a
//   character into one cell, clear all cells, or tick. Only a tick may produce a result,
//   one byte for the display link on the m_axis channel; tuser marks the two command
//   bytes and tlast marks the final pixel byte of a refresh.
//   A write or a clear is done as it is accepted. A tick that starts or continues a refresh
//   goes through accept, cell store read, font lookup and output load for a pixel byte;
//   a command byte is picked in the read step and skips the font lookup. The cell store
//   has one read port, and the font lookup waits for its registered data; that
//   read-then-lookup chain sets the tick rate. A tick with nothing pending gives no result.
//   The result waits in an output register; the block keeps taking writes and clears
//   while it waits, and a further tick stalls in its last step until the register is free.
//   Reset empties the output register, clears the dirty mark and the running refresh,
//   and marks every cell blank through per-cell valid bits; a clear marks every cell
//   blank the same way and sets the dirty mark. No clearing pass is needed.
`default_nettype none

module text_cell_display_refresher_core #(
  parameter int unsigned TEXT_ROWS = 8,
  parameter int unsigned TEXT_COLS = 21
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // column [4:0], row [7:5], char_code [14:8]
  input  wire logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte [7:0]
  output logic             m_axis_tuser,   // is_command [0]
  output logic             m_axis_tlast    // frame_end
);

  import tcdr_pkg::*;

  localparam int unsigned DEPTH  = TEXT_ROWS << COL_W;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic                dirty_q;
  logic                running_q;
  logic [DEPTH-1:0]    valid_q;
  logic                hit_q;
  logic [7:0]          byte_q;
  logic                cmd_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_cmd_q;
  logic                out_last_q;

  mode_e               mode;
  logic [COL_W-1:0]    column;
  logic [ROW_W-1:0]    row;
  logic [CODE_W-1:0]   char_code;
  map_t                map;
  logic                accept;
  logic                wr_ok;
  logic                tick_go;
  logic                out_free;
  logic                out_load;
  logic                cell_in;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [GLYPH_W-1:0]  rdata;
  logic [GLYPH_W-1:0]  glyph;
  scan_t               scan;

  // Input unpacking and decode.
  assign mode      = mode_e'(s_axis_tuser);
  assign column    = s_axis_tdata[4:0];
  assign row       = s_axis_tdata[7:5];
  assign char_code = s_axis_tdata[14:8];
  assign map       = map_code(char_code);

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_ok         = accept && mode == MODE_WRITE && map.hit &&
                         {1'b0, column} < (COL_W + 1)'(TEXT_COLS) &&
                         {1'b0, row} < (ROW_W + 1)'(TEXT_ROWS);
  assign tick_go       = accept && mode == MODE_TICK && (running_q || dirty_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = state_q == ST_EMIT && out_free;

  // Cell store addressing: row in the upper bits, column in the lower five.
  assign waddr   = ADDR_W'({row, column});
  assign raddr   = ADDR_W'({scan.page, scan.col});
  assign cell_in = {1'b0, scan.col} < (COL_W + 1)'(TEXT_COLS);

  tcdr_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(waddr),
    .wdata_i(map.glyph),
    .re_i   (state_q == ST_READ),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tcdr_scan #(
    .TEXT_ROWS(TEXT_ROWS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (tick_go && !running_q),
    .advance_i(state_q == ST_EMIT && out_free),
    .scan_o   (scan)
  );

  // A cell never written since the last clear reads as blank.
  assign glyph = hit_q ? rdata : '0;

  // Sequencer, cell valid bits and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dirty_q     <= 1'b0;
      running_q   <= 1'b0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      byte_q      <= '0;
      cmd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_cmd_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      // The output register fills in the last step of a tick and empties when taken.
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_WRITE: begin
                if (wr_ok) begin
                  valid_q[waddr] <= 1'b1;
                  dirty_q        <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                valid_q <= '0;
                dirty_q <= 1'b1;
              end
              MODE_TICK: begin
                if (tick_go) begin
                  if (!running_q) begin
                    running_q <= 1'b1;
                    dirty_q   <= 1'b0;
                  end
                  state_q <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (scan.header) begin
            byte_q  <= scan.cmd_high ? CMD_HIGH_COL : CMD_LOW_COL;
            cmd_q   <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            hit_q   <= cell_in && valid_q[raddr];
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          byte_q  <= font_byte(glyph, scan.sub);
          cmd_q   <= 1'b0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_byte_q  <= byte_q;
            out_cmd_q   <= cmd_q;
            out_last_q  <= scan.last;
            if (scan.last) begin
              running_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_cmd_q;
  assign m_axis_tlast  = out_last_q;

  // The end of a refresh is always a pixel byte.
  a_last_not_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("frame end marked on a command byte");

  // Command bytes carry only the two column commands.
  a_cmd_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == CMD_LOW_COL || m_axis_tdata == CMD_HIGH_COL))
    else $error("unexpected command byte");

  // A refresh ends only together with the frame end byte being loaded.
  a_end_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> m_axis_tvalid && m_axis_tlast)
    else $error("refresh stopped without frame end");

  // A tick on a dirty, idle screen starts a refresh and consumes the dirty mark.
  a_start_clears_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser == MODE_TICK && !running_q && dirty_q |=> running_q && !dirty_q)
    else $error("refresh start did not clear dirty mark");

endmodule

`default_nettype wire
